>>> sv/bap_pkg.sv
`timescale 1ns / 1ps
package bap_pkg;

  // Field widths
  localparam int BYTE_W    = 8;
  localparam int BUFLEN_W  = 16;
  localparam int SPS_W     = 24;
  localparam int EXTRA_W   = 16;
  localparam int LEN_W     = 24;
  localparam int COUNT_W   = 16;
  localparam int RES_W     = 16;
  localparam int SPS_FRAC  = 16;

  localparam logic [COUNT_W-1:0] MAX_PACKET_BYTES = 16'd65535;
  localparam logic [LEN_W-1:0]   LEN_MAX          = {LEN_W{1'b1}};

  // Shared bit-serial divider width: covers every numerator and divisor used
  localparam int DIV_W   = 33;
  localparam int DIV_CW  = $clog2(DIV_W + 1);

  // Back-end datapath widths
  localparam int PQ_W  = COUNT_W + DIV_W;   // quotient times step
  localparam int SUM_W = PQ_W + 1;          // head term + steps + extras
  localparam int PS_W  = LEN_W + SPS_W;     // length times samples per symbol
  localparam int SMP_W = PS_W + 1;          // sample total before rounding

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Configuration register map
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BUFFER_LEN    = 3'd0,
    REG_SPS_Q16       = 3'd1,
    REG_FILLER        = 3'd2,
    REG_EXTRA_SYMBOLS = 3'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [BUFLEN_W-1:0] buffer_len;
    logic [SPS_W-1:0]    sps_q16;
    logic [BYTE_W-1:0]   filler;
    logic [EXTRA_W-1:0]  extra_symbols;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] run_value;
    logic [LEN_W-1:0]  run_length;
    logic              is_fill;
    logic              end_of_packet;
    logic [LEN_W-1:0]  packet_symbols;
  } result_t;

  // Classified byte handed from front to back
  typedef struct packed {
    logic [BYTE_W-1:0]  data_byte;
    logic               last_byte;
    logic [COUNT_W-1:0] pkt_len;
  } cmd_t;

endpackage

>>> sv/bap_front.sv
`timescale 1ns / 1ps
module bap_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_stall,
  input  bap_pkg::item_t item,
  input  logic          q_full,
  output logic          push,
  output bap_pkg::cmd_t push_cmd
);
  import bap_pkg::*;

  logic [COUNT_W-1:0] byte_count;
  logic [COUNT_W-1:0] byte_count_next;

  // saturating packet length including this byte
  assign byte_count_next = (byte_count < MAX_PACKET_BYTES) ? byte_count + 1'b1 : byte_count;

  assign item_stall = q_full;
  assign push       = item_valid && !q_full;

  assign push_cmd.data_byte = item.data_byte;
  assign push_cmd.last_byte = item.last_byte;
  assign push_cmd.pkt_len   = byte_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else if (push) begin
      byte_count <= item.last_byte ? '0 : byte_count_next;
    end
  end

endmodule

>>> sv/bap_queue.sv
`timescale 1ns / 1ps
module bap_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bap_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output bap_pkg::cmd_t pop_cmd
);
  import bap_pkg::*;

  cmd_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wptr;
  logic [QUEUE_AW-1:0] rptr;
  logic [QUEUE_AW:0]   count;

  assign full      = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_cmd   = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> sv/bap_div.sv
`timescale 1ns / 1ps
module bap_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [bap_pkg::DIV_W-1:0] num,
  input  logic [bap_pkg::DIV_W-1:0] den,
  output logic                     done,
  output logic [bap_pkg::DIV_W-1:0] quo,
  output logic [bap_pkg::DIV_W-1:0] rem
);
  import bap_pkg::*;

  logic              busy;
  logic [DIV_CW-1:0] cnt;
  logic [DIV_W-1:0]  dvs;
  logic [DIV_W:0]    shifted;
  logic [DIV_W:0]    trial;

  // restoring division, one quotient bit per cycle
  assign shifted = {rem, quo[DIV_W-1]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == DIV_CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CW'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
      dvs <= den;
    end else if (busy) begin
      if (!trial[DIV_W]) begin
        rem <= trial[DIV_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DIV_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule

>>> sv/bap_back.sv
`timescale 1ns / 1ps
module bap_back (
  input  logic            clk,
  input  logic            rst,
  input  bap_pkg::cfg_t   cfg,
  input  logic            q_not_empty,
  input  bap_pkg::cmd_t   q_cmd,
  output logic            pop,
  output logic            result_valid,
  input  logic            result_stall,
  output bap_pkg::result_t result
);
  import bap_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_A_GO, S_A_WAIT, S_ST_GO, S_ST_WAIT, S_Q_GO, S_Q_WAIT,
    S_MUL_Q, S_LEN, S_MUL_S, S_MOD_GO, S_MOD_WAIT, S_EMIT
  } state_t;

  state_t               state;
  logic [COUNT_W-1:0]   n;
  logic [BUFLEN_W-1:0]  b;
  logic [SPS_W-1:0]     s;
  logic [RES_W-1:0]     residue;
  logic [DIV_W-1:0]     a;
  logic [DIV_W-1:0]     step;
  logic [COUNT_W-1:0]   q;
  logic [PQ_W-1:0]      prod_q;
  logic [LEN_W-1:0]     len;
  logic [PS_W-1:0]      prod_s;

  logic                 out_free;
  logic                 div_start;
  logic [DIV_W-1:0]     div_num;
  logic [DIV_W-1:0]     div_den;
  logic                 div_done;
  logic [DIV_W-1:0]     div_quo;
  logic [DIV_W-1:0]     div_rem;
  logic [DIV_W-1:0]     div_ceil;
  logic [SUM_W-1:0]     len_sum;
  logic [SMP_W-1:0]     samps_sum;

  assign out_free = !result_valid || !result_stall;
  assign pop      = (state == S_IDLE) && q_not_empty && out_free;
  assign div_ceil = div_quo + DIV_W'(div_rem != '0);
  assign len_sum  = SUM_W'(a) + SUM_W'(prod_q) + SUM_W'(cfg.extra_symbols);
  // residue and rounding half added in Q.SPS_FRAC before dropping the fraction
  assign samps_sum = SMP_W'({residue, {SPS_FRAC{1'b0}}}) + SMP_W'(prod_s)
                   + SMP_W'({1'b1, {(SPS_FRAC-1){1'b0}}});

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state)
      S_A_GO: begin
        div_start = (residue < b);
        div_num   = DIV_W'({(b - residue), {SPS_FRAC{1'b0}}});
        div_den   = DIV_W'(s);
      end
      S_ST_GO: begin
        div_start = 1'b1;
        div_num   = DIV_W'({b, {SPS_FRAC{1'b0}}});
        div_den   = DIV_W'(s);
      end
      S_Q_GO: begin
        div_start = (a < DIV_W'(n));
        div_num   = DIV_W'(n - a[COUNT_W-1:0]);
        div_den   = step;
      end
      S_MOD_GO: begin
        div_start = 1'b1;
        div_num   = DIV_W'(samps_sum[SMP_W-1:SPS_FRAC]);
        div_den   = DIV_W'(b);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  bap_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      residue      <= '0;
    end else begin
      // output register: loaded by a pop or the fill run, cleared once taken
      if (pop || ((state == S_EMIT) && out_free)) begin
        result_valid <= 1'b1;
      end else if (out_free) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            result.run_value      <= q_cmd.data_byte;
            result.run_length     <= LEN_W'(1);
            result.is_fill        <= 1'b0;
            result.end_of_packet  <= 1'b0;
            result.packet_symbols <= '0;
            if (q_cmd.last_byte) begin
              n     <= q_cmd.pkt_len;
              b     <= (cfg.buffer_len == '0) ? BUFLEN_W'(1) : cfg.buffer_len;
              s     <= (cfg.sps_q16 == '0) ? SPS_W'(1) : cfg.sps_q16;
              state <= S_A_GO;
            end
          end
        end
        S_A_GO: begin
          if (residue < b) begin
            state <= S_A_WAIT;
          end else begin
            a     <= '0;
            state <= S_ST_GO;
          end
        end
        S_A_WAIT: begin
          if (div_done) begin
            a     <= div_ceil;
            state <= S_ST_GO;
          end
        end
        S_ST_GO: begin
          state <= S_ST_WAIT;
        end
        S_ST_WAIT: begin
          if (div_done) begin
            step  <= div_ceil;
            state <= S_Q_GO;
          end
        end
        S_Q_GO: begin
          if (a < DIV_W'(n)) begin
            state <= S_Q_WAIT;
          end else begin
            q     <= '0;
            state <= S_MUL_Q;
          end
        end
        S_Q_WAIT: begin
          if (div_done) begin
            q     <= div_ceil[COUNT_W-1:0];
            state <= S_MUL_Q;
          end
        end
        S_MUL_Q: begin
          prod_q <= PQ_W'(q) * PQ_W'(step);
          state  <= S_LEN;
        end
        S_LEN: begin
          len   <= (len_sum > SUM_W'(LEN_MAX)) ? LEN_MAX : len_sum[LEN_W-1:0];
          state <= S_MUL_S;
        end
        S_MUL_S: begin
          prod_s <= PS_W'(len) * PS_W'(s);
          state  <= S_MOD_GO;
        end
        S_MOD_GO: begin
          state <= S_MOD_WAIT;
        end
        S_MOD_WAIT: begin
          if (div_done) begin
            residue <= div_rem[RES_W-1:0];
            state   <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            result.run_value      <= cfg.filler;
            result.run_length     <= len - LEN_W'(n);
            result.is_fill        <= 1'b1;
            result.end_of_packet  <= 1'b1;
            result.packet_symbols <= len;
            state                 <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sv/burst_alignment_padder.sv
`timescale 1ns / 1ps
// Burst alignment padder. Every accepted byte comes out as a run of length one
// (is_fill 0). After the last byte of a packet one fill run follows, with
// run_value = filler, run_length = padded length minus packet length (may be
// 0), end_of_packet 1 and packet_symbols = padded length. The padded length
// keeps the transmitted sample count aligned to buffer_len-sample buffers at
// sps_q16 samples per symbol (Q8.16), plus extra_symbols, saturating at
// 16777215; a running sample residue carries from packet to packet. Timing:
// data bytes move at one per cycle while the back end is idle and the output
// is not stalled. The fill run follows the last byte's data run once the
// padding math is done (sooner when a division is skipped, later while the
// output is stalled); that math runs on a single bit-serial divider, used up
// to four times per packet end, plus multiply, sum and emit states. During
// that time the front keeps taking bytes of the next packet into a four-entry
// command queue and stalls once it is full. Configuration writes are always
// ready and must only happen while the block is idle.
module burst_alignment_padder (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  bap_pkg::item_t                   item,
  output logic                             result_valid,
  input  logic                             result_stall,
  output bap_pkg::result_t                 result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bap_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bap_pkg::SPS_W-1:0]        cfg_data
);
  import bap_pkg::*;

  cfg_t cfg;

  // front -> queue -> back
  logic q_full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic q_not_empty;
  cmd_t q_cmd;

  // configuration: one write per transfer, never backpressured
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.buffer_len    <= BUFLEN_W'(4096);
      cfg.sps_q16       <= SPS_W'(65536);
      cfg.filler        <= '0;
      cfg.extra_symbols <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BUFFER_LEN:    cfg.buffer_len    <= cfg_data[BUFLEN_W-1:0];
        REG_SPS_Q16:       cfg.sps_q16       <= cfg_data;
        REG_FILLER:        cfg.filler        <= cfg_data[BYTE_W-1:0];
        REG_EXTRA_SYMBOLS: cfg.extra_symbols <= cfg_data[EXTRA_W-1:0];
        default: begin
          // unmapped index: write ignored
        end
      endcase
    end
  end

  // front: counts bytes, tags each byte with the saturated packet length so far
  bap_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_full     (q_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  // short command queue so the front keeps running during padding math
  bap_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .pop_cmd   (q_cmd)
  );

  // back: output register, padded-length and residue sequencer
  bap_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_not_empty  (q_not_empty),
    .q_cmd        (q_cmd),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

>>> sv/bap_checker.sv
`timescale 1ns / 1ps
module bap_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          result_valid,
  input logic                          result_stall,
  input bap_pkg::result_t              result
);
  import bap_pkg::*;

  // stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // data runs are single bytes, never end the packet
  a_data_run: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.is_fill |->
      result.run_length == LEN_W'(1) && !result.end_of_packet
      && result.packet_symbols == '0)
    else $error("malformed data run");

  // fill run closes the packet; padded length covers at least one data byte
  a_fill_run: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.is_fill |->
      result.end_of_packet && result.packet_symbols > result.run_length)
    else $error("malformed fill run");

  // nothing is presented right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind burst_alignment_padder bap_checker u_bap_checker (.*);
